// ----- src/cas_pkg.sv -----
// Package: shared types and constants of the cache attack score detector.
`timescale 1ns / 1ps
`default_nettype none
package cas_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 50;
    localparam int Q_W        = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSTR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CACHE = 2'd3;

    localparam logic [1:0] VERDICT_UNKNOWN   = 2'd0;
    localparam logic [1:0] VERDICT_NORMAL    = 2'd1;
    localparam logic [1:0] VERDICT_MALICIOUS = 2'd2;

    localparam logic [Q_W-1:0]    Q_ONE     = 17'h10000;
    localparam logic signed [17:0] Q_NEG_ONE = 18'sh30000;
    localparam logic [4:0]        DIV_STEPS = 5'd16;
    localparam logic [25:0]       RECIP5    = 26'd13421773;

    typedef struct packed {
        logic        entity_kind;
        logic [9:0]  entity_index;
        logic        fine_grain;
        logic [47:0] cycle_count;
        logic [47:0] instruction_count;
        logic [47:0] l3_misses;
        logic [47:0] l3_hits;
        logic [47:0] l2_hits;
        logic [47:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         verdict;
        logic signed [31:0] score_after;
    } t_out_item;

    typedef struct packed {
        logic [47:0]        detect_time;
        logic signed [31:0] score;
    } t_entry;

endpackage
`default_nettype wire

// ----- src/cas_mem.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cas_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  cas_pkg::t_entry       i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output cas_pkg::t_entry       o_rdata
);
    import cas_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- src/cas_div.sv -----
// Serial restoring divider giving a Q1.16 ratio of two counts.
`timescale 1ns / 1ps
`default_nettype none
module cas_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cas_pkg::DIV_W-1:0]    i_num,
    input  logic [cas_pkg::DIV_W-1:0]    i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [cas_pkg::Q_W-1:0]      o_quot
);
    import cas_pkg::*;

    logic             r_run;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= (i_num >= i_den) ? Q_ONE : '0;
                r_done <= (i_num >= i_den);
                if (i_num < i_den) begin
                    r_run <= 1'b1;
                    r_cnt <= DIV_STEPS;
                end
            end else if (r_run) begin
                r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
                r_quot <= {r_quot[Q_W-2:0], w_ge};
                r_cnt  <= r_cnt - 5'd1;
                r_done <= (r_cnt == 5'd1);
                if (r_cnt == 5'd1) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_busy = r_run;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- src/cache_attack_score_detector.sv -----
// Top level: per-entity cache attack scoring over core and process score memories.
// Steps: a scored sample passes READ, CHECK, DIV2, DIV3, SUM and FIN, paced by two serial
// 16-step ratio divisions; a thin sample READ, CHECK and FIN; an index beyond its table
// only FIN. Busy stays high until the result strobe, so a new item waits for that result.
// Reset: a clearing pass over max(CORE_COUNT, PROCESS_COUNT) entries zeroes both memories;
// busy is high meanwhile. The receiver cannot stall; each result strobes for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module cache_attack_score_detector #(
    parameter int CORE_COUNT    = 16,
    parameter int PROCESS_COUNT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  cas_pkg::t_in_item                i_item,
    output logic                             o_result_valid,
    output cas_pkg::t_out_item               o_result,
    input  logic                             i_cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import cas_pkg::*;

    localparam int CAW  = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int PAW  = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int MAXD = (CORE_COUNT > PROCESS_COUNT) ? CORE_COUNT : PROCESS_COUNT;
    localparam int MAW  = (MAXD > 1) ? $clog2(MAXD) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_CHECK = 8'b00001000,
        S_DIV2  = 8'b00010000,
        S_DIV3  = 8'b00100000,
        S_SUM   = 8'b01000000,
        S_FIN   = 8'b10000000
    } t_state;

    typedef struct packed {
        logic v2;
        logic v3;
        logic f2a;
        logic f2b;
        logic f2c;
        logic f3a;
        logic f3b;
        logic f3c;
        logic b3a;
        logic b3b;
        logic ia;
        logic ib;
        logic ic;
    } t_flags;

    t_state             r_state;
    logic [MAW-1:0]     r_clr_cnt;
    t_in_item           r_item;
    logic               r_oor;
    logic               r_unknown;
    logic signed [31:0] r_aged;
    logic [47:0]        r_old_time;
    logic [23:0]        r_min_i;
    logic [15:0]        r_min_c;
    logic [48:0]        r_l2miss;
    logic [49:0]        r_l2tot;
    t_flags             r_flags;
    logic signed [17:0] r_r2;
    logic signed [17:0] r_r3;
    logic signed [31:0] r_sum;
    logic [13:0]        r_core_thr;
    logic [13:0]        r_proc_thr;
    logic [23:0]        r_min_instr;
    logic [15:0]        r_min_cache;

    logic [31:0]        w_idx_in;
    logic [31:0]        w_idx_r;
    logic               w_oor_in;
    logic               w_accept;
    t_entry             w_core_rd;
    t_entry             w_proc_rd;
    t_entry             w_rd;
    logic               w_core_we;
    logic               w_proc_we;
    logic [CAW-1:0]     w_core_waddr;
    logic [PAW-1:0]     w_proc_waddr;
    t_entry             w_wdata;
    logic               w_clr_core;
    logic               w_clr_proc;
    logic               w_clr_last;
    logic signed [32:0] w_aged33;
    logic signed [32:0] w_dec;
    logic [48:0]        w_l2miss;
    logic [49:0]        w_mi_prod;
    logic [49:0]        w_mc_prod;
    logic               w_thin;
    t_flags             w_flags;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_num;
    logic [DIV_W-1:0]   w_div_den;
    logic               w_div_busy;
    logic               w_div_done;
    logic [Q_W-1:0]     w_quot;
    logic signed [17:0] w_ratio2;
    logic signed [17:0] w_ratio3;
    logic signed [33:0] w_r2x;
    logic signed [33:0] w_r3x;
    logic signed [33:0] w_inv3;
    logic signed [33:0] w_add2;
    logic signed [33:0] w_add3;
    logic signed [33:0] w_add4;
    logic signed [33:0] w_addi;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_sat;
    logic [13:0]        w_thr;
    logic signed [31:0] w_thr_q;
    logic               w_mal;
    t_out_item          w_out;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_idx_in = 32'(i_item.entity_index);
    assign w_idx_r  = 32'(r_item.entity_index);
    assign w_oor_in = i_item.entity_kind ? (w_idx_in >= 32'(PROCESS_COUNT))
                                         : (w_idx_in >= 32'(CORE_COUNT));

    assign w_clr_core = (r_state == S_CLEAR) && (32'(r_clr_cnt) < 32'(CORE_COUNT));
    assign w_clr_proc = (r_state == S_CLEAR) && (32'(r_clr_cnt) < 32'(PROCESS_COUNT));
    assign w_clr_last = (32'(r_clr_cnt) == 32'(MAXD - 1));

    assign w_rd = r_item.entity_kind ? w_proc_rd : w_core_rd;

    assign w_dec    = r_item.fine_grain ? 33'sd262144 : 33'sd655360;
    assign w_aged33 = 33'(w_rd.score) - w_dec;
    assign w_l2miss = 49'(r_item.l3_misses) + 49'(r_item.l3_hits);
    assign w_mi_prod = 50'(r_min_instr) * 50'(RECIP5);
    assign w_mc_prod = 50'(r_min_cache) * 50'(RECIP5);

    assign w_thin = (r_item.instruction_count < 48'(r_min_i))
                 || (r_l2tot < 50'(r_min_c))
                 || (r_item.cycle_count == 48'd0);

    always_comb begin
        w_flags.v2  = (r_l2tot != 50'd0);
        w_flags.v3  = (r_l2miss != 49'd0);
        w_flags.f2a = w_flags.v2 && (56'(r_l2miss) * 56'd20 > 56'(r_l2tot) * 56'd19);
        w_flags.f2b = w_flags.v2 && (56'(r_l2miss) * 56'd10 > 56'(r_l2tot) * 56'd9);
        w_flags.f2c = w_flags.v2 && (56'(r_l2miss) * 56'd20 > 56'(r_l2tot) * 56'd17);
        w_flags.f3a = w_flags.v3
                   && (56'(r_item.l3_misses) * 56'd20 > 56'(r_l2miss) * 56'd19);
        w_flags.f3b = w_flags.v3
                   && (56'(r_item.l3_misses) * 56'd10 > 56'(r_l2miss) * 56'd9);
        w_flags.f3c = w_flags.v3
                   && (56'(r_item.l3_misses) * 56'd5 > 56'(r_l2miss) * 56'd4);
        w_flags.b3a = !w_flags.v3
                   || (56'(r_item.l3_misses) * 56'd100 < 56'(r_l2miss) * 56'd3);
        w_flags.b3b = !w_flags.v3
                   || (56'(r_item.l3_misses) * 56'd2 < 56'(r_l2miss));
        w_flags.ia  = 52'(r_item.instruction_count) * 52'd10
                    < 52'(r_item.cycle_count) * 52'd3;
        w_flags.ib  = 52'(r_item.instruction_count) * 52'd2 < 52'(r_item.cycle_count);
        w_flags.ic  = 52'(r_item.instruction_count) * 52'd5
                    < 52'(r_item.cycle_count) * 52'd4;
    end

    assign w_div_start = ((r_state == S_CHECK) && !w_thin)
                      || ((r_state == S_DIV2) && w_div_done);
    assign w_div_num = (r_state == S_CHECK) ? {1'b0, r_l2miss} : 50'(r_item.l3_misses);
    assign w_div_den = (r_state == S_CHECK) ? r_l2tot : 50'(r_l2miss);
    assign w_ratio2  = r_flags.v2 ? 18'({1'b0, w_quot}) : Q_NEG_ONE;
    assign w_ratio3  = r_flags.v3 ? 18'({1'b0, w_quot}) : Q_NEG_ONE;

    assign w_r2x  = 34'(r_r2);
    assign w_r3x  = 34'(r_r3);
    assign w_inv3 = 34'sd65536 - w_r3x;

    always_comb begin
        w_add2 = '0;
        w_add3 = '0;
        w_add4 = '0;
        w_addi = '0;
        if (r_item.fine_grain) begin
            if (r_flags.f2a)      w_add2 = w_r2x * 34'sd10;
            else if (r_flags.f2b) w_add2 = w_r2x * 34'sd7;
            else if (r_flags.f2c) w_add2 = w_r2x * 34'sd5;
            if (r_flags.f3a)      w_add3 = w_r3x * 34'sd4;
            else if (r_flags.f3b) w_add3 = w_r3x * 34'sd2;
            else if (r_flags.f3c) w_add3 = w_r3x;
            if (r_flags.b3a)      w_add4 = w_inv3 * 34'sd4;
            else if (r_flags.b3b) w_add4 = w_inv3 * 34'sd2;
            if (r_flags.ia)       w_addi = 34'sd196608;
            else if (r_flags.ib)  w_addi = 34'sd131072;
            else if (r_flags.ic)  w_addi = 34'sd65536;
        end else begin
            if (r_flags.f2a)      w_add2 = w_r2x * 34'sd30;
            else if (r_flags.f2b) w_add2 = w_r2x * 34'sd20;
            else if (r_flags.f2c) w_add2 = w_r2x * 34'sd10;
            if (r_flags.f3a || r_flags.b3a)      w_add3 = w_r3x * 34'sd15;
            else if (r_flags.f3b || r_flags.b3b) w_add3 = w_r3x * 34'sd10;
            else if (r_flags.f3c)                w_add3 = w_r3x * 34'sd5;
            if (r_flags.ia)       w_addi = 34'sd327680;
            else if (r_flags.ib)  w_addi = 34'sd196608;
            else if (r_flags.ic)  w_addi = 34'sd131072;
        end
    end

    assign w_sum = 34'(r_aged) + w_add2 + w_add3 + w_add4 + w_addi;

    always_comb begin
        if (w_sum > 34'sd2147483647) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum < -34'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign w_thr   = r_item.entity_kind ? r_proc_thr : r_core_thr;
    assign w_thr_q = $signed({2'b00, w_thr, 16'h0000});
    assign w_mal   = !r_unknown && (r_sum > w_thr_q);

    always_comb begin
        if (r_oor) begin
            w_out.verdict     = VERDICT_UNKNOWN;
            w_out.score_after = '0;
        end else if (r_unknown) begin
            w_out.verdict     = VERDICT_UNKNOWN;
            w_out.score_after = r_aged;
        end else if (w_mal) begin
            w_out.verdict     = VERDICT_MALICIOUS;
            w_out.score_after = '0;
        end else begin
            w_out.verdict     = VERDICT_NORMAL;
            w_out.score_after = r_sum;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wdata = '0;
        end else begin
            w_wdata.score       = w_out.score_after;
            w_wdata.detect_time = w_mal ? r_item.sample_time : r_old_time;
        end
    end

    assign w_core_we = w_clr_core
                    || ((r_state == S_FIN) && !r_oor && !r_item.entity_kind);
    assign w_proc_we = w_clr_proc
                    || ((r_state == S_FIN) && !r_oor && r_item.entity_kind);
    assign w_core_waddr = (r_state == S_CLEAR) ? r_clr_cnt[CAW-1:0] : w_idx_r[CAW-1:0];
    assign w_proc_waddr = (r_state == S_CLEAR) ? r_clr_cnt[PAW-1:0] : w_idx_r[PAW-1:0];

    cas_mem #(
        .DEPTH  (CORE_COUNT),
        .ADDR_W (CAW)
    ) u_core_mem (
        .i_clk   (i_clk),
        .i_we    (w_core_we),
        .i_waddr (w_core_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx_in[CAW-1:0]),
        .o_rdata (w_core_rd)
    );

    cas_mem #(
        .DEPTH  (PROCESS_COUNT),
        .ADDR_W (PAW)
    ) u_proc_mem (
        .i_clk   (i_clk),
        .i_we    (w_proc_we),
        .i_waddr (w_proc_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx_in[PAW-1:0]),
        .o_rdata (w_proc_rd)
    );

    cas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_thr  <= 14'd100;
            r_proc_thr  <= 14'd100;
            r_min_instr <= 24'd500000;
            r_min_cache <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CORE_THR:  r_core_thr  <= i_cfg_wdata[13:0];
                CFG_PROC_THR:  r_proc_thr  <= i_cfg_wdata[13:0];
                CFG_MIN_INSTR: r_min_instr <= i_cfg_wdata;
                CFG_MIN_CACHE: r_min_cache <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_cnt      <= '0;
            o_result_valid <= 1'b0;
            r_oor          <= 1'b0;
            r_unknown      <= 1'b0;
        end else begin
            o_result_valid <= (r_state == S_FIN);
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (w_clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_item    <= i_item;
                        r_oor     <= w_oor_in;
                        r_unknown <= 1'b0;
                        r_state   <= w_oor_in ? S_FIN : S_READ;
                    end
                end
                S_READ: begin
                    r_aged     <= w_aged33[32] ? 32'sd0 : w_aged33[31:0];
                    r_old_time <= w_rd.detect_time;
                    r_l2miss   <= w_l2miss;
                    r_l2tot    <= 50'(w_l2miss) + 50'(r_item.l2_hits);
                    r_min_i    <= r_item.fine_grain ? w_mi_prod[49:26] : r_min_instr;
                    r_min_c    <= r_item.fine_grain ? w_mc_prod[41:26] : r_min_cache;
                    r_state    <= S_CHECK;
                end
                S_CHECK: begin
                    r_flags <= w_flags;
                    if (w_thin) begin
                        r_unknown <= 1'b1;
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_r2    <= w_ratio2;
                        r_state <= S_DIV3;
                    end
                end
                S_DIV3: begin
                    if (w_div_done) begin
                        r_r3    <= w_ratio3;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum   <= w_sat;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_result <= w_out;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_strobe_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_FIN))
        else $error("result strobe without a finishing step");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_mal_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.verdict == VERDICT_MALICIOUS))
        |-> (o_result.score_after == 32'sd0))
        else $error("malicious transaction left a nonzero score");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while running");

    a_oor_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(r_oor)) |-> (o_result.verdict == VERDICT_UNKNOWN))
        else $error("out-of-range index gave a known verdict");

endmodule
`default_nettype wire
